@@ rtl/packed_pixel_sprite_blitter_top_assert.svh @@
// Assertion macros shared by the blitter RTL.
`ifndef PACKED_PIXEL_SPRITE_BLITTER_TOP_ASSERT_SVH
`define PACKED_PIXEL_SPRITE_BLITTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPSB_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPSB_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/ppsb_pkg.sv @@
package ppsb_pkg;

  localparam int unsigned BYTES_PER_ROW = 32;
  localparam int unsigned MAX_ROWS      = 32;

  localparam int unsigned DEPTH  = MAX_ROWS * BYTES_PER_ROW;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

  // Height register and the capped height, which may reach MAX_ROWS.
  localparam int unsigned HEIGHT_W     = 6;
  localparam int unsigned H_W          = 7;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd16;

  // Request stream layout.
  localparam int unsigned X_W     = 9;
  localparam int unsigned Y_W     = 7;
  localparam int unsigned BCOL_W  = 6;
  localparam int unsigned BROW_W  = 6;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COLOR_W = 2;
  localparam int unsigned FUNC_W  = 2;

  localparam int unsigned X_LSB     = 0;
  localparam int unsigned Y_LSB     = X_LSB + X_W;
  localparam int unsigned BCOL_LSB  = Y_LSB + Y_W;
  localparam int unsigned BROW_LSB  = BCOL_LSB + BCOL_W;
  localparam int unsigned DATA_LSB  = BROW_LSB + BROW_W;
  localparam int unsigned COLOR_LSB = DATA_LSB + DATA_W;
  localparam int unsigned IN_BITS   = COLOR_LSB + COLOR_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = DATA_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BLIT  = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_B0,
    S_B1,
    S_DONE
  } state_e;

  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd1;

  localparam logic [DATA_W-1:0] FILT_ALL   = 8'hFF;
  localparam logic [DATA_W-1:0] FILT_GREEN = 8'hAA;
  localparam logic [DATA_W-1:0] FILT_RED   = 8'h55;
  // One full pixel at the leftmost place of a byte.
  localparam logic [DATA_W-1:0] PIXEL_LEFT = 8'hC0;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    mem_addr = ADDR_W'(row) * ADDR_W'(BYTES_PER_ROW) + ADDR_W'(col);
  endfunction

endpackage

@@ rtl/packed_pixel_sprite_blitter_top.sv @@
// Packed-pixel frame store with sprite blitter for a two-colour LED panel.
// Requests arrive on the s_axis channel: tuser carries the operation (clear,
// blit sprite byte, set pixel, read byte), tdata the coordinates, sprite byte
// and colour. Every request gives exactly one response on m_axis: tdata is the
// byte read (zero for the other operations) and tuser echoes the operation.
// The display height register is written through cfg_valid_i/cfg_data_i while
// the block is idle; the user must keep to this, the block does not enforce it.
// cfg_ready_o is always high. The store is a single-port-write, registered-read
// memory; every change is a read-modify-write through it. A read, a set pixel
// or a one-byte blit answers from S_B0; a blit that spills into a second byte
// writes it in S_B1 and answers from there. The block takes no new request
// until the current one has answered. A clear sweeps all 1024 bytes, one per
// cycle, answering at its end; after reset it also runs, with s_axis_tready low.
// The response sits in an output register, so a new request is taken while it
// waits; if the receiver stalls long enough for a second response to finish,
// the block holds it and deasserts s_axis_tready until the first is taken.
`include "packed_pixel_sprite_blitter_top_assert.svh"

module packed_pixel_sprite_blitter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request: x_pos[8:0], y_pos[15:9], byte_col[21:16], byte_row[27:22],
  // data_byte[35:28], color[37:36], zero fill above.
  input  logic [ppsb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Request: func[1:0].
  input  logic [ppsb_pkg::FUNC_W-1:0]          s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Response: read_data[7:0].
  output logic [ppsb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Response: done_func[1:0].
  output logic [ppsb_pkg::FUNC_W-1:0]          m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppsb_pkg::HEIGHT_W-1:0]        cfg_data_i
);
  import ppsb_pkg::*;

  localparam logic signed [7:0] BPR_S  = 8'(BYTES_PER_ROW);
  localparam logic signed [7:0] ROWS_S = 8'(MAX_ROWS);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_req_q, clr_req_d;
  logic [HEIGHT_W-1:0] height_q;

  // Registered request.
  func_e             op_q;
  logic              wr0_q, wr1_q, rd_ok_q;
  logic [ADDR_W-1:0] addr0_q, addr1_q;
  logic [DATA_W-1:0] val0_q, val1_q;
  logic [DATA_W-1:0] hold_q, hold_d;
  logic              load_item;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  func_e             m_user_q, m_user_d;
  logic              out_free;

  // Memory port.
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;

  // Request decode.
  func_e              in_func;
  logic [X_W-1:0]     in_x;
  logic [Y_W-1:0]     in_y;
  logic [BCOL_W-1:0]  in_bcol;
  logic [BROW_W-1:0]  in_brow;
  logic [DATA_W-1:0]  in_data;
  logic [COLOR_W-1:0] in_color;
  logic [DATA_W-1:0]  filt, data_eff;
  logic [2*DATA_W-1:0] spread;
  logic signed [7:0]  xcol_s, row_s, col_s, col1_s;
  logic [H_W-1:0]     h_eff;
  logic               row_ok, row_in_store, col0_ok, col1_ok;
  logic               wr0_d, wr1_d, rd_ok_d;
  logic [ADDR_W-1:0]  addr0_d, addr1_d;

  assign in_func  = func_e'(s_axis_tuser);
  assign in_x     = s_axis_tdata[X_LSB +: X_W];
  assign in_y     = s_axis_tdata[Y_LSB +: Y_W];
  assign in_bcol  = s_axis_tdata[BCOL_LSB +: BCOL_W];
  assign in_brow  = s_axis_tdata[BROW_LSB +: BROW_W];
  assign in_data  = s_axis_tdata[DATA_LSB +: DATA_W];
  assign in_color = s_axis_tdata[COLOR_LSB +: COLOR_W];

  assign h_eff = (H_W'(height_q) > H_W'(MAX_ROWS)) ? H_W'(MAX_ROWS) : H_W'(height_q);

  always_comb begin
    case (in_color)
      COLOR_GREEN: filt = FILT_GREEN;
      COLOR_RED:   filt = FILT_RED;
      default:     filt = FILT_ALL;
    endcase
  end

  // A set pixel is a one-pixel blit that never reaches the next byte.
  assign data_eff = (in_func == FUNC_SET) ? PIXEL_LEFT : in_data;
  assign spread   = {data_eff & filt, DATA_W'(0)} >> {in_x[1:0], 1'b0};

  // Arithmetic shift gives the floor division of x by four.
  assign xcol_s = 8'(signed'(in_x[X_W-1:2]));
  assign row_s  = 8'(signed'(in_y)) +
                  ((in_func == FUNC_BLIT) ? signed'({2'b00, in_brow}) : 8'sd0);
  assign col_s  = ((in_func == FUNC_READ) ? 8'sd0 : xcol_s) +
                  ((in_func == FUNC_SET) ? 8'sd0 : signed'({2'b00, in_bcol}));
  assign col1_s = col_s + 8'sd1;

  assign row_ok       = (row_s >= 8'sd0) && (row_s < signed'({1'b0, h_eff}));
  assign row_in_store = (row_s >= 8'sd0) && (row_s < ROWS_S);
  assign col0_ok      = (col_s >= 8'sd0) && (col_s < BPR_S);
  assign col1_ok      = (col1_s >= 8'sd0) && (col1_s < BPR_S);

  assign wr0_d   = ((in_func == FUNC_BLIT) || (in_func == FUNC_SET)) && row_ok && col0_ok;
  assign wr1_d   = (in_func == FUNC_BLIT) && (in_x[1:0] != 2'b00) && row_ok && col1_ok;
  assign rd_ok_d = (in_func == FUNC_READ) && row_in_store && col0_ok;
  assign addr0_d = mem_addr(row_s[ROW_W-1:0], col_s[COL_W-1:0]);
  assign addr1_d = mem_addr(row_s[ROW_W-1:0], col1_s[COL_W-1:0]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign load_item     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    logic          fin;
    logic [DATA_W-1:0] res;
    fin       = 1'b0;
    res       = '0;
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    clr_req_d = clr_req_q;
    hold_d    = hold_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    we        = 1'b0;
    waddr     = addr0_q;
    wdata     = rdata_q | val0_q;
    raddr     = addr0_q;
    case (state_q)
      S_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = '0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          clr_req_d = 1'b0;
          if (clr_req_q) begin
            fin = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        raddr = addr0_d;
        if (load_item) begin
          if (in_func == FUNC_CLEAR) begin
            state_d   = S_CLEAR;
            clr_cnt_d = '0;
            clr_req_d = 1'b1;
          end else begin
            state_d = S_B0;
          end
        end
      end
      S_B0: begin
        we    = wr0_q;
        raddr = addr1_q;
        if (wr1_q) begin
          state_d = S_B1;
        end else begin
          fin = 1'b1;
          if (rd_ok_q) begin
            res = rdata_q;
          end
        end
      end
      S_B1: begin
        we    = 1'b1;
        waddr = addr1_q;
        wdata = rdata_q | val1_q;
        fin   = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = hold_q;
          m_user_d  = op_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_data_d  = res;
        m_user_d  = op_q;
        state_d   = S_IDLE;
      end else begin
        hold_d  = res;
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      clr_req_q <= 1'b0;
      m_valid_q <= 1'b0;
      height_q  <= HEIGHT_RESET;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_req_q <= clr_req_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    hold_q   <= hold_d;
    if (load_item) begin
      op_q    <= in_func;
      wr0_q   <= wr0_d;
      wr1_q   <= wr1_d;
      rd_ok_q <= rd_ok_d;
      addr0_q <= addr0_d;
      addr1_q <= addr1_d;
      val0_q  <= spread[2*DATA_W-1:DATA_W];
      val1_q  <= spread[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `PPSB_ASSERT_NOW(a_b1_needs_spill, state_q == S_B1, wr1_q,
    "second byte cycle entered for a request without spill")
  `PPSB_ASSERT_NEXT(a_read_goes_b0, load_item && (in_func == FUNC_READ), state_q == S_B0,
    "read request did not start its memory cycle")
  `PPSB_ASSERT_NOW(a_done_waits_full, state_q == S_DONE, m_valid_q,
    "held response waiting while output register is empty")
  `PPSB_ASSERT_NOW(a_resp_from_work, $rose(m_valid_q), $past(state_q) != S_IDLE,
    "response appeared without a request being worked on")

endmodule
